/* rtl/apc_pkg.sv */
// Package for the attitude pointing constraint check.
// Holds widths, register indexes and shared types; no dependencies.
package apc_pkg;

    localparam int BoresightsPerKind = 2;
    localparam int AddrW = 6;

    typedef enum logic [2:0] {
        REG_KO_DIR  = 3'd0,
        REG_KI_DIR  = 3'd1,
        REG_KO_CNT  = 3'd2,
        REG_KI_CNT  = 3'd3,
        REG_KO_BS_A = 3'd4,
        REG_KO_BS_B = 3'd5,
        REG_KI_BS_A = 3'd6,
        REG_KI_BS_B = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [48:0] ko_dir;
        logic [48:0] ki_dir;
        logic [1:0]  ko_cnt;
        logic [1:0]  ki_cnt;
        logic [63:0] ko_bs_a;
        logic [63:0] ko_bs_b;
        logic [63:0] ki_bs_a;
        logic [63:0] ki_bs_b;
    } t_cfg;

    localparam logic signed [35:0] OneQ28 = 36'sd268435456;
    localparam logic signed [35:0] BoundTol = 36'sd5368;

    function automatic logic [1:0] clamp_cnt(input logic [1:0] c);
        clamp_cnt = (c > 2'(BoresightsPerKind)) ? 2'(BoresightsPerKind) : c;
    endfunction

endpackage

/* rtl/apc_cone.sv */
// One cone test pipeline stage set: rotate a boresight and compare against the cone.
// Uses no package. Inputs are registered matrix terms; three register stages.
module apc_cone (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [35:0] i_m [3][3],
    input  logic signed [37:0] i_ph2,
    input  logic [63:0]        i_bore,
    input  logic [47:0]        i_dir,
    output logic               o_in
);
    logic signed [15:0] b [3];
    logic signed [15:0] d [3];
    logic signed [15:0] c;
    logic signed [51:0] r_p [3][3];
    logic signed [15:0] r_d1 [3];
    logic signed [51:0] r_cp;
    logic signed [39:0] r_v [3];
    logic signed [15:0] r_d2 [3];
    logic signed [51:0] r_cp2;
    logic signed [55:0] n_dot;
    logic signed [55:0] v_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b[i] = i_bore[16*i +: 16];
            d[i] = i_dir[16*i +: 16];
        end
        c = i_bore[63:48];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= 52'(b[i]) * 52'(i_m[i][j]);
                end
            end
            r_d1 <= d;
            r_cp <= 52'(c) * 52'(i_ph2);
            for (int j = 0; j < 3; j++) begin
                r_v[j] <= 40'((54'(r_p[0][j]) + 54'(r_p[1][j]) + 54'(r_p[2][j])) >>> 14);
            end
            r_d2 <= r_d1;
            r_cp2 <= r_cp;
            o_in <= n_dot >= 56'(r_cp2);
        end
    end

    always_comb begin
        v_sum = '0;
        for (int j = 0; j < 3; j++) begin
            v_sum = v_sum + 56'(r_v[j]) * 56'(r_d2[j]);
        end
        n_dot = v_sum;
    end
endmodule

/* rtl/attitude_pointing_constraint_check_top.sv */
// Top level of the attitude pointing constraint check.
// Throughput one item per cycle while the pipeline is not held; results are registered.
// The pipeline is held as a whole while the output register is full and not taken.
// Reset clears the stage valid bits and all configuration registers to zero.
// Depends on apc_pkg and apc_cone.
module attitude_pointing_constraint_check_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [15:0]            i_mrp_x,
    input  logic signed [15:0]            i_mrp_y,
    input  logic signed [15:0]            i_mrp_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_attitude_free,
    output logic                          o_on_boundary,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apc_pkg::AddrW-1:0]     paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    localparam int Depth = 7;
    apc_pkg::t_cfg r_cfg;
    logic [Depth-1:0] r_vld;
    logic en;
    logic [2:0] widx;

    assign pready = 1'b1;
    assign widx = paddr[5:3];
    assign en = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[Depth-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            unique case (apc_pkg::t_reg_idx'(widx))
                apc_pkg::REG_KO_DIR:  r_cfg.ko_dir <= pwdata[48:0];
                apc_pkg::REG_KI_DIR:  r_cfg.ki_dir <= pwdata[48:0];
                apc_pkg::REG_KO_CNT:  r_cfg.ko_cnt <= pwdata[1:0];
                apc_pkg::REG_KI_CNT:  r_cfg.ki_cnt <= pwdata[1:0];
                apc_pkg::REG_KO_BS_A: r_cfg.ko_bs_a <= pwdata;
                apc_pkg::REG_KO_BS_B: r_cfg.ko_bs_b <= pwdata;
                apc_pkg::REG_KI_BS_A: r_cfg.ki_bs_a <= pwdata;
                apc_pkg::REG_KI_BS_B: r_cfg.ki_bs_b <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (apc_pkg::t_reg_idx'(widx))
            apc_pkg::REG_KO_DIR:  prdata = 64'(r_cfg.ko_dir);
            apc_pkg::REG_KI_DIR:  prdata = 64'(r_cfg.ki_dir);
            apc_pkg::REG_KO_CNT:  prdata = 64'(r_cfg.ko_cnt);
            apc_pkg::REG_KI_CNT:  prdata = 64'(r_cfg.ki_cnt);
            apc_pkg::REG_KO_BS_A: prdata = r_cfg.ko_bs_a;
            apc_pkg::REG_KO_BS_B: prdata = r_cfg.ko_bs_b;
            apc_pkg::REG_KI_BS_A: prdata = r_cfg.ki_bs_a;
            apc_pkg::REG_KI_BS_B: prdata = r_cfg.ki_bs_b;
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end

    // stage 1: squares and products
    logic signed [31:0] r_sq [3];
    logic signed [31:0] r_xy, r_xz, r_yz;
    logic signed [15:0] r_q1 [3];
    // stage 2: n2, sh, ph
    logic signed [35:0] r_n2;
    logic signed [31:0] r_sq2 [3];
    logic signed [31:0] r_xy2, r_xz2, r_yz2;
    logic signed [15:0] r_q2 [3];
    logic signed [21:0] r_sh;
    logic signed [21:0] r_ph;
    logic r_bnd2;
    // stage 3: matrix
    logic signed [35:0] r_m [3][3];
    logic signed [37:0] r_ph2;
    logic r_bnd [4];
    logic signed [35:0] n_n2, dev;
    logic signed [43:0] ss, qsh [3];

    always_comb begin
        n_n2 = 36'(r_sq[0]) + 36'(r_sq[1]) + 36'(r_sq[2]);
        dev = n_n2 - apc_pkg::OneQ28;
        ss = 44'(r_sh) * 44'(r_sh);
        for (int i = 0; i < 3; i++) qsh[i] = 44'(r_q2[i]) * 44'(r_sh);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1[0] <= i_mrp_x;
            r_q1[1] <= i_mrp_y;
            r_q1[2] <= i_mrp_z;
            r_sq[0] <= 32'(i_mrp_x) * 32'(i_mrp_x);
            r_sq[1] <= 32'(i_mrp_y) * 32'(i_mrp_y);
            r_sq[2] <= 32'(i_mrp_z) * 32'(i_mrp_z);
            r_xy <= 32'(i_mrp_x) * 32'(i_mrp_y);
            r_xz <= 32'(i_mrp_x) * 32'(i_mrp_z);
            r_yz <= 32'(i_mrp_y) * 32'(i_mrp_z);

            r_n2 <= n_n2;
            r_sq2 <= r_sq;
            r_xy2 <= r_xy;
            r_xz2 <= r_xz;
            r_yz2 <= r_yz;
            r_q2 <= r_q1;
            r_sh <= 22'((apc_pkg::OneQ28 - n_n2) >>> 14);
            r_ph <= 22'((apc_pkg::OneQ28 + n_n2) >>> 14);
            r_bnd2 <= dev <= apc_pkg::BoundTol && dev >= -apc_pkg::BoundTol;

            for (int i = 0; i < 3; i++) begin
                r_m[i][i] <= 36'(44'sd4 * (44'sd2 * 44'(r_sq2[i]) - 44'(r_n2)) + ss);
            end
            r_m[0][1] <= 36'(44'sd8 * 44'(r_xy2) + 44'sd4 * qsh[2]);
            r_m[0][2] <= 36'(44'sd8 * 44'(r_xz2) - 44'sd4 * qsh[1]);
            r_m[1][0] <= 36'(44'sd8 * 44'(r_xy2) - 44'sd4 * qsh[2]);
            r_m[1][2] <= 36'(44'sd8 * 44'(r_yz2) + 44'sd4 * qsh[0]);
            r_m[2][0] <= 36'(44'sd8 * 44'(r_xz2) + 44'sd4 * qsh[1]);
            r_m[2][1] <= 36'(44'sd8 * 44'(r_yz2) - 44'sd4 * qsh[0]);
            r_ph2 <= 38'(44'(r_ph) * 44'(r_ph));
            r_bnd[0] <= r_bnd2;
            for (int i = 1; i < 4; i++) r_bnd[i] <= r_bnd[i-1];
        end
    end

    logic [3:0] hit;
    apc_cone u_ko_a (.i_clk, .i_en(en), .i_m(r_m), .i_ph2(r_ph2), .i_bore(r_cfg.ko_bs_a),
        .i_dir(r_cfg.ko_dir[47:0]), .o_in(hit[0]));
    apc_cone u_ko_b (.i_clk, .i_en(en), .i_m(r_m), .i_ph2(r_ph2), .i_bore(r_cfg.ko_bs_b),
        .i_dir(r_cfg.ko_dir[47:0]), .o_in(hit[1]));
    apc_cone u_ki_a (.i_clk, .i_en(en), .i_m(r_m), .i_ph2(r_ph2), .i_bore(r_cfg.ki_bs_a),
        .i_dir(r_cfg.ki_dir[47:0]), .o_in(hit[2]));
    apc_cone u_ki_b (.i_clk, .i_en(en), .i_m(r_m), .i_ph2(r_ph2), .i_bore(r_cfg.ki_bs_b),
        .i_dir(r_cfg.ki_dir[47:0]), .o_in(hit[3]));

    logic [1:0] ko_n, ki_n;
    logic ko_bad, ki_ok;
    always_comb begin
        ko_n = apc_pkg::clamp_cnt(r_cfg.ko_cnt);
        ki_n = apc_pkg::clamp_cnt(r_cfg.ki_cnt);
        ko_bad = r_cfg.ko_dir[48] && ((hit[0] && ko_n >= 2'd1) || (hit[1] && ko_n >= 2'd2));
        ki_ok = !r_cfg.ki_dir[48] || (hit[2] && ki_n >= 2'd1) || (hit[3] && ki_n >= 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_attitude_free <= !ko_bad && ki_ok;
            o_on_boundary <= r_bnd[3];
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_on_boundary))
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("stalled with empty output");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && !r_vld[Depth-2] |=> !o_valid) else $error("invented result");
endmodule

/* tb/sv/tb_top.sv */
// Testbench for attitude_pointing_constraint_check_top: APB register setup, streamed
// attitudes with random idling on both sides, results checked against a cone predictor.
// Depends on apc_pkg and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic free_att;
        logic bound;
    } t_verdict;

    class cone_scoreboard;
        logic [48:0] ko_dir, ki_dir;
        logic [1:0]  ko_cnt, ki_cnt;
        logic [63:0] ko_bs[2], ki_bs[2];
        t_verdict    verdicts[$];
        int          errors;

        function new();
            ko_dir = '0; ki_dir = '0; ko_cnt = '0; ki_cnt = '0;
            ko_bs[0] = '0; ko_bs[1] = '0; ki_bs[0] = '0; ki_bs[1] = '0;
            errors = 0;
        endfunction

        function void set_reg(apc_pkg::t_reg_idx idx, logic [63:0] val);
            case (idx)
                apc_pkg::REG_KO_DIR:  ko_dir = val[48:0];
                apc_pkg::REG_KI_DIR:  ki_dir = val[48:0];
                apc_pkg::REG_KO_CNT:  ko_cnt = val[1:0];
                apc_pkg::REG_KI_CNT:  ki_cnt = val[1:0];
                apc_pkg::REG_KO_BS_A: ko_bs[0] = val;
                apc_pkg::REG_KO_BS_B: ko_bs[1] = val;
                apc_pkg::REG_KI_BS_A: ki_bs[0] = val;
                default:              ki_bs[1] = val;
            endcase
        endfunction

        function bit boresight_inside(longint m[3][3], longint ph2, logic [63:0] bs,
                                      logic [48:0] dir);
            longint b[3], d[3], v, dot, c;
            dot = 0;
            c = longint'($signed(bs[63:48]));
            for (int i = 0; i < 3; i++) begin
                b[i] = longint'($signed(bs[16*i +: 16]));
                d[i] = longint'($signed(dir[16*i +: 16]));
            end
            for (int j = 0; j < 3; j++) begin
                v = 0;
                for (int i = 0; i < 3; i++) v += b[i] * m[i][j];
                dot += (v >>> 14) * d[j];
            end
            return dot >= c * ph2;
        endfunction

        function void note_attitude(logic signed [15:0] x, logic signed [15:0] y,
                                    logic signed [15:0] z);
            longint q1, q2, q3, n2, sh, ph, ph2, ss, dev;
            longint m[3][3];
            int cnt;
            bit hit_any;
            t_verdict r;
            q1 = x; q2 = y; q3 = z;
            n2 = q1*q1 + q2*q2 + q3*q3;
            sh = (longint'(1 << 28) - n2) >>> 14;
            ph = (longint'(1 << 28) + n2) >>> 14;
            ph2 = ph * ph;
            ss = sh * sh;
            m[0][0] = 4*(2*q1*q1 - n2) + ss;
            m[0][1] = 8*q1*q2 + 4*q3*sh;
            m[0][2] = 8*q1*q3 - 4*q2*sh;
            m[1][0] = 8*q2*q1 - 4*q3*sh;
            m[1][1] = 4*(2*q2*q2 - n2) + ss;
            m[1][2] = 8*q2*q3 + 4*q1*sh;
            m[2][0] = 8*q3*q1 + 4*q2*sh;
            m[2][1] = 8*q3*q2 - 4*q1*sh;
            m[2][2] = 4*(2*q3*q3 - n2) + ss;
            r.free_att = 1'b1;
            if (ko_dir[48]) begin
                cnt = (ko_cnt > 2) ? 2 : ko_cnt;
                for (int k = 0; k < cnt; k++)
                    if (boresight_inside(m, ph2, ko_bs[k], ko_dir)) r.free_att = 1'b0;
            end
            if (ki_dir[48]) begin
                hit_any = 0;
                cnt = (ki_cnt > 2) ? 2 : ki_cnt;
                for (int k = 0; k < cnt; k++)
                    if (boresight_inside(m, ph2, ki_bs[k], ki_dir)) hit_any = 1;
                if (!hit_any) r.free_att = 1'b0;
            end
            dev = n2 - longint'(1 << 28);
            r.bound = (dev <= 5368 && dev >= -5368);
            verdicts.push_back(r);
        endfunction

        function void check_verdict(logic free_att, logic bound);
            t_verdict e;
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result free=%b boundary=%b", $time, free_att, bound);
                errors++;
                return;
            end
            e = verdicts.pop_front();
            if (free_att !== e.free_att) begin
                $display("%0t: attitude_free expected %b actual %b", $time, e.free_att, free_att);
                errors++;
            end
            if (bound !== e.bound) begin
                $display("%0t: on_boundary expected %b actual %b", $time, e.bound, bound);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0, o_ready;
    logic signed [15:0] i_mrp_x = '0, i_mrp_y = '0, i_mrp_z = '0;
    logic o_valid, i_ready = 1'b0;
    logic o_attitude_free, o_on_boundary;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [apc_pkg::AddrW-1:0] paddr = '0;
    logic [63:0] pwdata = '0, prdata;
    logic pready;

    cone_scoreboard sb = new();
    bit calm = 1'b0;
    int cycles = 0;

    attitude_pointing_constraint_check_top u_top (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_verdict(o_attitude_free, o_on_boundary);
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
    end

    task automatic write_reg(apc_pkg::t_reg_idx idx, logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= apc_pkg::AddrW'(8 * int'(idx)); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic send_attitude(logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z);
        if (!calm && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mrp_x <= x; i_mrp_y <= y; i_mrp_z <= z;
        do @(posedge i_clk); while (!o_ready);
        sb.note_attitude(x, y, z);
    endtask

    function automatic logic signed [15:0] rand_q();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return rand_q();
        endcase
    endfunction

    function automatic logic [63:0] rand_bs();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    task automatic rand_attitude();
        logic signed [15:0] a, b;
        a = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
        b = 16'($signed($urandom_range(400)) - 200);
        case ($urandom_range(9))
            0: send_attitude(a, b, 16'($signed($urandom_range(8)) - 4));
            1: send_attitude(b, 16'sd16383, 16'($signed($urandom_range(400)) - 200));
            2: send_attitude(16'($urandom_range(9000)), 16'($urandom_range(9000)),
                             16'($urandom_range(9000)));
            default: send_attitude(rand_q(), rand_q(), rand_q());
        endcase
    endtask

    task automatic configure(bit extremes);
        write_reg(apc_pkg::REG_KO_DIR,
                  {15'd0, 1'($urandom), rand_word(), rand_word(), rand_word()});
        write_reg(apc_pkg::REG_KI_DIR,
                  {15'd0, 1'($urandom), rand_word(), rand_word(), rand_word()});
        write_reg(apc_pkg::REG_KO_CNT, 64'($urandom_range(3)));
        write_reg(apc_pkg::REG_KI_CNT, 64'($urandom_range(3)));
        write_reg(apc_pkg::REG_KO_BS_A, rand_bs());
        write_reg(apc_pkg::REG_KO_BS_B, rand_bs());
        write_reg(apc_pkg::REG_KI_BS_A, rand_bs());
        write_reg(apc_pkg::REG_KI_BS_B, rand_bs());
        if (extremes) begin
            write_reg(apc_pkg::REG_KO_DIR, {15'd0, 49'h1_FFFF_FFFF_FFFF});
            write_reg(apc_pkg::REG_KI_DIR, {15'd0, 1'b1, 16'sd0, 16'sd0, 16'sd16384});
            write_reg(apc_pkg::REG_KO_CNT, 64'd3);
            write_reg(apc_pkg::REG_KI_CNT, 64'd0);
            write_reg(apc_pkg::REG_KO_BS_A, 64'hFFFF_FFFF_FFFF_FFFF);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config, then a cone along x with keep-in along z
        send_attitude(16'sd0, 16'sd0, 16'sd0);
        send_attitude(16'sd16384, 16'sd0, 16'sd0);
        send_attitude(-16'sd16384, -16'sd16384, -16'sd16384);
        drain();
        write_reg(apc_pkg::REG_KO_DIR, {15'd0, 1'b1, 16'sd0, 16'sd0, 16'sd16384});
        write_reg(apc_pkg::REG_KI_DIR, {15'd0, 1'b1, 16'sd16384, 16'sd0, 16'sd0});
        write_reg(apc_pkg::REG_KO_CNT, 64'd1);
        write_reg(apc_pkg::REG_KI_CNT, 64'd2);
        write_reg(apc_pkg::REG_KO_BS_A, {16'sd15000, 16'sd0, 16'sd0, 16'sd16384});
        write_reg(apc_pkg::REG_KO_BS_B, {16'sd0, 16'sd0, 16'sd16384, 16'sd0});
        write_reg(apc_pkg::REG_KI_BS_A, {-16'sd16384, 16'sd16384, 16'sd0, 16'sd0});
        write_reg(apc_pkg::REG_KI_BS_B, {16'sd16384, 16'sd0, 16'sd0, 16'sd16384});
        send_attitude(16'sd0, 16'sd0, 16'sd0);
        send_attitude(16'sd16384, 16'sd0, 16'sd0);
        send_attitude(16'sd16384, 16'sd73, 16'sd0);
        send_attitude(16'sd16384, 16'sd74, 16'sd0);
        send_attitude(16'sd16383, 16'sd0, 16'sd0);
        send_attitude(16'sd16383, 16'sd181, 16'sd0);
        send_attitude(-16'sd16384, 16'sd0, 16'sd0);
        send_attitude(16'sd0, 16'sd16384, 16'sd0);
        send_attitude(16'sd0, 16'sd0, -16'sd16384);
        send_attitude(16'sd16384, 16'sd16384, 16'sd16384);
        send_attitude(16'sd8192, -16'sd8192, 16'sd8192);
        send_attitude(16'sd6000, 16'sd0, 16'sd0);
        send_attitude(16'sd0, 16'sd0, 16'sd6000);
        drain();
        write_reg(apc_pkg::REG_KI_CNT, 64'd0);
        send_attitude(16'sd1000, 16'sd2000, 16'sd3000);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            configure(ph == 5);
            calm = (ph == 2);
            repeat (90) rand_attitude();
            if (ph == 3) begin
                drain();
            end
            drain();
        end
        calm = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.verdicts.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
